### hw/rtl/blf_pkg.sv
// ---------------------------------------------------------------------------
// blf_pkg
// Shared widths, constants, command/status words and the CORDIC angle table
// for the binary image line fit block.
// ---------------------------------------------------------------------------
package blf_pkg;

  localparam int MAX_ROWS     = 1024;
  localparam int MAX_COLS     = 1024;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int STEP_N       = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  localparam int SIZE_W = 11;
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int CNT_W  = 21;
  localparam int SUM_W  = 30;
  localparam int SQ_W   = 40;

  localparam int MUL_AW = 40;
  localparam int MUL_BW = 30;
  localparam int PW     = MUL_AW + MUL_BW;
  localparam int DIV_NW = 35;
  localparam int DIV_DW = CNT_W;
  localparam int MOM_W  = 64;
  localparam int MAG_W  = 63;

  localparam int CW     = 34;
  localparam int ZW     = 35;
  localparam int ITER_W = 5;
  localparam int SEL_W  = 3;
  localparam int CFG_IDX_W = 4;

  localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(480);
  localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(640);

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = CFG_IDX_W'(1);

  // product sequence for the scaled covariances
  localparam logic [SEL_W-1:0] MUL_N_RR  = SEL_W'(0);
  localparam logic [SEL_W-1:0] MUL_RR_RR = SEL_W'(1);
  localparam logic [SEL_W-1:0] MUL_N_CC  = SEL_W'(2);
  localparam logic [SEL_W-1:0] MUL_CC_CC = SEL_W'(3);
  localparam logic [SEL_W-1:0] MUL_N_RC  = SEL_W'(4);
  localparam logic [SEL_W-1:0] MUL_R_C   = SEL_W'(5);
  localparam logic [SEL_W-1:0] MUL_LAST  = MUL_R_C;

  localparam logic [SEL_W-1:0] DIV_ROW  = SEL_W'(0);
  localparam logic [SEL_W-1:0] DIV_COL  = SEL_W'(1);
  localparam logic [SEL_W-1:0] DIV_LAST = DIV_COL;

  localparam logic signed [CW-1:0] GAIN_INV  = CW'(652032874);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'd2147483648);

  typedef struct packed {
    logic              acc_en;
    logic              mul_start;
    logic              mul_store;
    logic              div_start;
    logic              div_store;
    logic              prep;
    logic              norm_step;
    logic              vec_init;
    logic              vec_step;
    logic              rot_init;
    logic              rot_step;
    logic              out_fire;
    logic [SEL_W-1:0]  sel;
    logic [ITER_W-1:0] iter;
  } blf_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic n_zero;
    logic mul_done;
    logic div_done;
    logic vec_zero;
    logic norm_ok;
  } blf_stat_t;

  // angle of atan(2^-i), 2^32 units per turn
  function automatic logic [29:0] atan_unit(input logic [ITER_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/blf_mul.sv
// ---------------------------------------------------------------------------
// blf_mul
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module blf_mul
  import blf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MUL_AW-1:0] a,
  input  logic [MUL_BW-1:0] b,
  output logic [PW-1:0]     prod,
  output logic              done
);

  localparam int MC_W = $clog2(MUL_BW + 1);

  logic            run;
  logic [MC_W-1:0] cnt;
  logic [PW-1:0]   acc;
  logic [MUL_AW-1:0] areg;
  logic [MUL_AW:0] sum;

  assign sum  = {1'b0, acc[PW-1:MUL_BW]} + (acc[0] ? {1'b0, areg} : '0);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + MC_W'(1);
        if (cnt == MC_W'(MUL_BW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= {{MUL_AW{1'b0}}, b};
      areg <= a;
    end else if (run) begin
      acc <= {sum, acc[MUL_BW-1:1]};
    end
  end

endmodule

### hw/rtl/blf_div.sv
// ---------------------------------------------------------------------------
// blf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module blf_div
  import blf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_NW-1:0] quo,
  output logic              done
);

  localparam int DC_W = $clog2(DIV_NW + 1);

  logic              run;
  logic [DC_W-1:0]   cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dreg;
  logic [DIV_NW-1:0] q;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign rem_sh = {rem, q[DIV_NW-1]};
  assign ge     = rem_sh >= {1'b0, dreg};
  assign diff   = rem_sh - {1'b0, dreg};
  assign quo    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + DC_W'(1);
        if (cnt == DC_W'(DIV_NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      q    <= num;
      dreg <= den;
    end else if (run) begin
      rem <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
      q   <= {q[DIV_NW-2:0], ge};
    end
  end

endmodule

### hw/rtl/blf_ctrl.sv
// ---------------------------------------------------------------------------
// blf_ctrl
// Sequencer: pixel accumulation, then the end-of-frame solve steps.
// ---------------------------------------------------------------------------
module blf_ctrl
  import blf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  blf_stat_t stat,
  output blf_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [3:0] {
    S_ACC, S_CHECK, S_MUL_GO, S_MUL_WAIT, S_DIV_GO, S_DIV_WAIT,
    S_PREP, S_NORM, S_VEC, S_ROT_INIT, S_ROT, S_OUT
  } state_t;

  state_t            state;
  logic [SEL_W-1:0]  sel;
  logic [ITER_W-1:0] iter;

  assign busy = (state != S_ACC);

  always_comb begin
    cmd      = '0;
    cmd.sel  = sel;
    cmd.iter = iter;
    case (state)
      S_ACC:      cmd.acc_en    = start;
      S_MUL_GO:   cmd.mul_start = 1'b1;
      S_MUL_WAIT: cmd.mul_store = stat.mul_done;
      S_DIV_GO:   cmd.div_start = 1'b1;
      S_DIV_WAIT: cmd.div_store = stat.div_done;
      S_PREP:     cmd.prep      = 1'b1;
      S_NORM: begin
        cmd.vec_init  = stat.norm_ok;
        cmd.norm_step = !stat.norm_ok;
      end
      S_VEC:      cmd.vec_step  = 1'b1;
      S_ROT_INIT: cmd.rot_init  = 1'b1;
      S_ROT:      cmd.rot_step  = 1'b1;
      S_OUT:      cmd.out_fire  = 1'b1;
      default:    cmd           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      sel   <= '0;
      iter  <= '0;
    end else begin
      case (state)
        S_ACC: begin
          if (start && stat.frame_end) state <= S_CHECK;
        end
        S_CHECK: begin
          sel   <= MUL_N_RR;
          state <= stat.n_zero ? S_OUT : S_MUL_GO;
        end
        S_MUL_GO: state <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (stat.mul_done) begin
            if (sel == MUL_LAST) begin
              sel   <= DIV_ROW;
              state <= S_DIV_GO;
            end else begin
              sel   <= sel + SEL_W'(1);
              state <= S_MUL_GO;
            end
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (stat.div_done) begin
            if (sel == DIV_LAST) begin
              state <= S_PREP;
            end else begin
              sel   <= sel + SEL_W'(1);
              state <= S_DIV_GO;
            end
          end
        end
        S_PREP: state <= stat.vec_zero ? S_ROT_INIT : S_NORM;
        S_NORM: begin
          if (stat.norm_ok) begin
            iter  <= '0;
            state <= S_VEC;
          end
        end
        S_VEC: begin
          iter <= iter + ITER_W'(1);
          if (iter == ITER_W'(STEP_N - 1)) state <= S_ROT_INIT;
        end
        S_ROT_INIT: begin
          iter  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          iter <= iter + ITER_W'(1);
          if (iter == ITER_W'(STEP_N - 1)) state <= S_OUT;
        end
        S_OUT:   state <= S_ACC;
        default: state <= S_ACC;
      endcase
    end
  end

endmodule

### hw/rtl/blf_dp.sv
// ---------------------------------------------------------------------------
// blf_dp
// Datapath: size registers, raster counters, moment accumulators, serial
// multiply/divide, normalization and the shared CORDIC stage.
// ---------------------------------------------------------------------------
module blf_dp
  import blf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data,
  input  logic                  pixel_on,
  input  blf_cmd_t              cmd,
  output blf_stat_t             stat,
  output logic                  done,
  output logic                  fit_valid,
  output logic signed [15:0]    dir_cos,
  output logic signed [15:0]    dir_sin,
  output logic [13:0]           centroid_row,
  output logic [13:0]           centroid_col,
  output logic [CNT_W-1:0]      point_count
);

  logic [SIZE_W-1:0] image_rows;
  logic [SIZE_W-1:0] image_cols;
  logic [SIZE_W-1:0] rows_eff;
  logic [SIZE_W-1:0] cols_eff;
  logic [ROW_W-1:0]  row_pos;
  logic [COL_W-1:0]  col_pos;
  logic              col_last;
  logic              row_last;

  logic [CNT_W-1:0]  set_count;
  logic [SUM_W-1:0]  sum_row;
  logic [SUM_W-1:0]  sum_col;
  logic [SQ_W-1:0]   sum_row_sq;
  logic [SQ_W-1:0]   sum_col_sq;
  logic [SQ_W-1:0]   sum_row_col;
  logic [2*ROW_W-1:0]     row_sq;
  logic [2*COL_W-1:0]     col_sq;
  logic [ROW_W+COL_W-1:0] row_col;

  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [PW-1:0]     mul_p;
  logic signed [MOM_W-1:0] prod;
  logic signed [MOM_W-1:0] mx_x;
  logic signed [MOM_W-1:0] mx_y;

  logic [DIV_NW-1:0] div_n;
  logic [DIV_NW-1:0] div_q;
  logic [13:0]       div_sat;
  logic [13:0]       cen_row;
  logic [13:0]       cen_col;

  logic [MAG_W-1:0]  mag_x;
  logic [MAG_W-1:0]  mag_y;
  logic [MAG_W-1:0]  mag_or;
  logic              sgn_x;
  logic              sgn_y;
  logic              norm_hi;
  logic              norm_lo;

  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic signed [ZW-1:0] z;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] at;
  logic signed [CW-1:0] my_s;

  function automatic logic [15:0] sat_q15(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    logic signed [CW:0] s;
    logic [15:0]        r;
    t = {v[CW-1], v} + (CW+1)'(16384);
    s = t >>> 15;
    if (s > $signed((CW+1)'(32767)))       r = 16'h7fff;
    else if (s < -$signed((CW+1)'(32768))) r = 16'h8000;
    else                                   r = s[15:0];
    return r;
  endfunction

  // size registers, zero means one, clamp to the maximum
  always_comb begin
    rows_eff = image_rows;
    if (image_rows == '0) rows_eff = SIZE_W'(1);
    else if (image_rows > SIZE_W'(MAX_ROWS)) rows_eff = SIZE_W'(MAX_ROWS);
    cols_eff = image_cols;
    if (image_cols == '0) cols_eff = SIZE_W'(1);
    else if (image_cols > SIZE_W'(MAX_COLS)) cols_eff = SIZE_W'(MAX_COLS);
  end

  assign col_last = (SIZE_W'(col_pos) + SIZE_W'(1)) >= cols_eff;
  assign row_last = (SIZE_W'(row_pos) + SIZE_W'(1)) >= rows_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= ROWS_RESET;
      image_cols <= COLS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IMAGE_ROWS) image_rows <= cfg_data;
      if (cfg_index == CFG_IMAGE_COLS) image_cols <= cfg_data;
    end
  end

  assign row_sq  = {{ROW_W{1'b0}}, row_pos} * {{ROW_W{1'b0}}, row_pos};
  assign col_sq  = {{COL_W{1'b0}}, col_pos} * {{COL_W{1'b0}}, col_pos};
  assign row_col = {{COL_W{1'b0}}, row_pos} * {{ROW_W{1'b0}}, col_pos};

  // raster counters and moments
  always_ff @(posedge clk) begin
    if (rst || cmd.out_fire) begin
      row_pos     <= '0;
      col_pos     <= '0;
      set_count   <= '0;
      sum_row     <= '0;
      sum_col     <= '0;
      sum_row_sq  <= '0;
      sum_col_sq  <= '0;
      sum_row_col <= '0;
    end else if (cmd.acc_en) begin
      if (pixel_on) begin
        set_count   <= set_count + CNT_W'(1);
        sum_row     <= sum_row + SUM_W'(row_pos);
        sum_col     <= sum_col + SUM_W'(col_pos);
        sum_row_sq  <= sum_row_sq + SQ_W'(row_sq);
        sum_col_sq  <= sum_col_sq + SQ_W'(col_sq);
        sum_row_col <= sum_row_col + SQ_W'(row_col);
      end
      if (!col_last) begin
        col_pos <= col_pos + COL_W'(1);
      end else begin
        col_pos <= '0;
        row_pos <= row_last ? '0 : row_pos + ROW_W'(1);
      end
    end
  end

  // covariance products
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.sel)
      MUL_N_RR: begin
        mul_a = sum_row_sq;
        mul_b = MUL_BW'(set_count);
      end
      MUL_RR_RR: begin
        mul_a = MUL_AW'(sum_row);
        mul_b = sum_row;
      end
      MUL_N_CC: begin
        mul_a = sum_col_sq;
        mul_b = MUL_BW'(set_count);
      end
      MUL_CC_CC: begin
        mul_a = MUL_AW'(sum_col);
        mul_b = sum_col;
      end
      MUL_N_RC: begin
        mul_a = sum_row_col;
        mul_b = MUL_BW'(set_count);
      end
      MUL_R_C: begin
        mul_a = MUL_AW'(sum_row);
        mul_b = sum_col;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  blf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_p),
    .done  (stat.mul_done)
  );

  assign prod = $signed(mul_p[MOM_W-1:0]);

  // mx_x = N^2*(var_r - var_c), mx_y = 2*N^2*cov_rc
  always_ff @(posedge clk) begin
    if (cmd.mul_store) begin
      case (cmd.sel)
        MUL_N_RR:  mx_x <= prod;
        MUL_RR_RR: mx_x <= mx_x - prod;
        MUL_N_CC:  mx_x <= mx_x - prod;
        MUL_CC_CC: mx_x <= mx_x + prod;
        MUL_N_RC:  mx_y <= prod <<< 1;
        MUL_R_C:   mx_y <= mx_y - (prod <<< 1);
        default:   mx_x <= mx_x;
      endcase
    end
  end

  // centroids: (sum*16 + n/2) / n
  assign div_n = (cmd.sel == DIV_COL) ?
                 ({sum_col, 4'b0} + DIV_NW'(set_count >> 1)) :
                 ({sum_row, 4'b0} + DIV_NW'(set_count >> 1));
  assign div_sat = (|div_q[DIV_NW-1:14]) ? 14'h3fff : div_q[13:0];

  blf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_n),
    .den   (set_count),
    .quo   (div_q),
    .done  (stat.div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      if (cmd.sel == DIV_COL) cen_col <= div_sat;
      else                    cen_row <= div_sat;
    end
  end

  // magnitude normalization to [2^29, 2^30)
  assign mag_or  = mag_x | mag_y;
  assign norm_hi = |mag_or[MAG_W-1:30];
  assign norm_lo = ~|mag_or[MAG_W-1:29];

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      sgn_x <= mx_x[MOM_W-1];
      sgn_y <= mx_y[MOM_W-1];
      mag_x <= mx_x[MOM_W-1] ? MAG_W'(-mx_x) : MAG_W'(mx_x);
      mag_y <= mx_y[MOM_W-1] ? MAG_W'(-mx_y) : MAG_W'(mx_y);
    end else if (cmd.norm_step) begin
      if (norm_hi) begin
        mag_x <= mag_x >> 1;
        mag_y <= mag_y >> 1;
      end else begin
        mag_x <= mag_x << 1;
        mag_y <= mag_y << 1;
      end
    end
  end

  // shared CORDIC stage: vectoring then rotation
  assign dx   = py >>> cmd.iter;
  assign dy   = px >>> cmd.iter;
  assign at   = $signed(ZW'(atan_unit(cmd.iter)));
  assign my_s = $signed(CW'(mag_y[29:0]));

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      z <= '0;
    end else if (cmd.vec_init) begin
      // left half plane folds over by half a turn
      px <= $signed(CW'(mag_x[29:0]));
      py <= (sgn_x ^ sgn_y) ? -my_s : my_s;
      z  <= sgn_x ? (sgn_y ? -HALF_TURN : HALF_TURN) : '0;
    end else if (cmd.vec_step) begin
      if (!py[CW-1]) begin
        px <= px + dx;
        py <= py - dy;
        z  <= z + at;
      end else begin
        px <= px - dx;
        py <= py + dy;
        z  <= z - at;
      end
    end else if (cmd.rot_init) begin
      px <= GAIN_INV;
      py <= '0;
      z  <= z >>> 1;
    end else if (cmd.rot_step) begin
      if (!z[ZW-1]) begin
        px <= px - dx;
        py <= py + dy;
        z  <= z - at;
      end else begin
        px <= px + dx;
        py <= py - dy;
        z  <= z + at;
      end
    end
  end

  assign stat.frame_end = col_last && row_last;
  assign stat.n_zero    = (set_count == '0);
  assign stat.vec_zero  = (mx_x == '0) && (mx_y == '0);
  assign stat.norm_ok   = !norm_hi && !norm_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fire) begin
      fit_valid    <= !stat.n_zero;
      dir_cos      <= stat.n_zero ? '0 : $signed(sat_q15(px));
      dir_sin      <= stat.n_zero ? '0 : $signed(sat_q15(py));
      centroid_row <= stat.n_zero ? '0 : cen_row;
      centroid_col <= stat.n_zero ? '0 : cen_col;
      point_count  <= set_count;
    end
  end

endmodule

### hw/rtl/binary_image_line_fit_top.sv
// ---------------------------------------------------------------------------
// binary_image_line_fit_top
// Principal-axis line fit over a binary image streamed in raster order.
// ---------------------------------------------------------------------------
// Pixels: drive pixel_on with start; a pixel word is taken on each edge with
// start high and busy low, one per cycle while a frame streams in.
// Size: image_rows (index 0) and image_cols (index 1) are written on the cfg
// channel; cfg_ready is always high. Zero reads as one, large values clamp.
// At the last pixel of a frame busy rises and the solve runs: six serial
// shift-add products, two restoring divisions, normalization shifts and
// two 16-step CORDIC passes; a degenerate spread skips normalization and
// vectoring, and an empty frame skips the whole solve. The result word
// then shows for one cycle with done high, busy drops and the next frame
// may start; the receiver cannot stall.
// Reset restores 480 x 640 and clears counters and sums; no result pending.
// ---------------------------------------------------------------------------
module binary_image_line_fit_top
  import blf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 pixel_on,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  output logic                 done,
  output logic                 fit_valid,
  output logic signed [15:0]   dir_cos,
  output logic signed [15:0]   dir_sin,
  output logic [13:0]          centroid_row,
  output logic [13:0]          centroid_col,
  output logic [CNT_W-1:0]     point_count
);

  blf_cmd_t  cmd;
  blf_stat_t stat;

  assign cfg_ready = 1'b1;

  blf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  blf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_on     (pixel_on),
    .cmd          (cmd),
    .stat         (stat),
    .done         (done),
    .fit_valid    (fit_valid),
    .dir_cos      (dir_cos),
    .dir_sin      (dir_sin),
    .centroid_row (centroid_row),
    .centroid_col (centroid_col),
    .point_count  (point_count)
  );

endmodule
